### hw/rtl/lcdtx_pkg.sv
// Shared types, codes and helpers for the LCD text-to-telegram converter.
package lcdtx_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] lead_t;
    typedef logic [1:0] slot_t;

    // Telegram start bytes: register select clear for commands, set for characters
    localparam byte_t START_BYTE = 8'hF8;
    localparam byte_t RS_BIT     = 8'h02;

    localparam byte_t CMD_CLEAR  = 8'h01;
    localparam byte_t CMD_HOME   = 8'h02;

    localparam byte_t LEAD_C3    = 8'hC3;
    localparam byte_t LEAD_C2    = 8'hC2;

    localparam byte_t SUBST_RESET = 8'h15;

    // Held lead byte codes
    localparam lead_t PEND_NONE = 2'd0;
    localparam lead_t PEND_C3   = 2'd1;
    localparam lead_t PEND_C2   = 2'd2;

    // Frame slot within one job: two command telegrams, then the character
    localparam slot_t FRAME_CLEAR = 2'd0;
    localparam slot_t FRAME_HOME  = 2'd1;
    localparam slot_t FRAME_CHAR  = 2'd2;

    // Byte slot within one telegram
    localparam slot_t BYTE_START = 2'd0;
    localparam slot_t BYTE_LO    = 2'd1;
    localparam slot_t BYTE_HI    = 2'd2;

    function automatic logic [3:0] rev_nibble(input logic [3:0] nib);
        return {nib[0], nib[1], nib[2], nib[3]};
    endfunction

    // Second byte after a 0xC3 lead: German letters to Latin-1, else substitute
    function automatic byte_t umlaut_map(input byte_t second, input byte_t subst);
        byte_t res;
        case (second)
            8'hA4:   res = 8'hE4;
            8'hB6:   res = 8'hF6;
            8'hBC:   res = 8'hFC;
            8'h84:   res = 8'hC4;
            8'h96:   res = 8'hD6;
            8'h9C:   res = 8'hDC;
            8'h9F:   res = 8'hDF;
            default: res = subst;
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/lcdtx_if.sv
// Valid/ready channel interfaces for text input and serial telegram output.
interface lcdtx_text_if;
    logic                 valid;
    logic                 ready;
    lcdtx_pkg::byte_t     text_byte;
    logic                 first_of_text;

    modport source (output valid, output text_byte, output first_of_text, input ready);
    modport sink   (input valid, input text_byte, input first_of_text, output ready);
endinterface

interface lcdtx_serial_if;
    logic                 valid;
    logic                 ready;
    lcdtx_pkg::byte_t     serial_byte;
    logic                 frame_end;
    logic                 run_end;

    modport source (output valid, output serial_byte, output frame_end, output run_end,
                    input ready);
    modport sink   (input valid, input serial_byte, input frame_end, input run_end,
                    output ready);
endinterface

### hw/rtl/lcd_text_to_serial_frames.sv
// Top level: UTF-8 text bytes in, three-byte LCD serial telegrams out.
//
// in_text carries one text byte per transfer, with first_of_text marking the
// start of a new text. out_serial carries one telegram byte per transfer;
// frame_end flags the third byte of a telegram, run_end the last byte caused
// by one input byte. cfg_wr_en/cfg_wr_data load the substitute character.
//
// A text byte is decoded in the cycle it is transferred and loaded into a job
// register; its first telegram byte is valid in the next cycle. The job
// register sends one byte per cycle while the receiver is ready: a plain
// character gives one telegram, a start-of-text byte two or three. A lead
// byte (0xC3, 0xC2) is held and sends nothing unless it starts a text. A new
// byte is taken in the cycle the last byte of the current job is transferred,
// so the output runs without gaps. When the receiver stalls, the current byte
// holds and input stays blocked once the job register is busy.
// Reset clears the job valid flag and the held lead byte and sets the
// substitute character to 0x15.
module lcd_text_to_serial_frames (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  lcdtx_pkg::byte_t         cfg_wr_data,
    lcdtx_text_if.sink               in_text,
    lcdtx_serial_if.source           out_serial
);
    import lcdtx_pkg::*;

    logic   job_valid_reg, job_valid_next;
    logic   job_char_reg, job_char_next;
    byte_t  job_value_reg, job_value_next;
    slot_t  frame_reg, frame_next;
    slot_t  byte_reg, byte_next;
    lead_t  pend_reg, pend_next;
    byte_t  subst_reg;

    logic   in_xfer;
    logic   out_xfer;
    slot_t  last_frame;
    logic   last_byte;
    lead_t  pend_eff;
    logic   dec_char;
    logic   dec_load;
    byte_t  dec_value;
    byte_t  frame_value;
    logic   frame_is_char;

    assign in_xfer    = in_text.valid && in_text.ready;
    assign out_xfer   = out_serial.valid && out_serial.ready;
    assign last_frame = job_char_reg ? FRAME_CHAR : FRAME_HOME;
    assign last_byte  = (byte_reg == BYTE_HI) && (frame_reg == last_frame);

    assign in_text.ready = !job_valid_reg || (out_serial.ready && last_byte);

    // Decode the incoming byte against the held lead
    always_comb
    begin
        pend_eff  = in_text.first_of_text ? PEND_NONE : pend_reg;
        dec_char  = 1'b1;
        dec_value = in_text.text_byte;
        pend_next = PEND_NONE;
        unique case (pend_eff)
            PEND_C3:
            begin
                dec_value = umlaut_map(in_text.text_byte, subst_reg);
            end
            PEND_C2:
            begin
                dec_value = subst_reg;
            end
            default:
            begin
                if (in_text.text_byte == LEAD_C3)
                begin
                    dec_char  = 1'b0;
                    pend_next = PEND_C3;
                end
                else if (in_text.text_byte == LEAD_C2)
                begin
                    dec_char  = 1'b0;
                    pend_next = PEND_C2;
                end
            end
        endcase
        dec_load = in_text.first_of_text || dec_char;
    end

    // Job sequencer: advance byte and frame slots, load a new job on transfer
    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_char_next  = job_char_reg;
        job_value_next = job_value_reg;
        frame_next     = frame_reg;
        byte_next      = byte_reg;
        if (out_xfer)
        begin
            if (last_byte)
            begin
                job_valid_next = 1'b0;
            end
            else if (byte_reg == BYTE_HI)
            begin
                frame_next = frame_reg + 2'd1;
                byte_next  = BYTE_START;
            end
            else
            begin
                byte_next = byte_reg + 2'd1;
            end
        end
        if (in_xfer && dec_load)
        begin
            job_valid_next = 1'b1;
            job_char_next  = dec_char;
            job_value_next = dec_value;
            frame_next     = in_text.first_of_text ? FRAME_CLEAR : FRAME_CHAR;
            byte_next      = BYTE_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            frame_reg     <= FRAME_CLEAR;
            byte_reg      <= BYTE_START;
            pend_reg      <= PEND_NONE;
            subst_reg     <= SUBST_RESET;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            frame_reg     <= frame_next;
            byte_reg      <= byte_next;
            if (in_xfer)
            begin
                pend_reg <= pend_next;
            end
            if (cfg_wr_en)
            begin
                subst_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_char_reg  <= job_char_next;
        job_value_reg <= job_value_next;
    end

    // Build the current telegram byte
    always_comb
    begin
        frame_is_char = (frame_reg == FRAME_CHAR);
        if (frame_reg == FRAME_CLEAR)
        begin
            frame_value = CMD_CLEAR;
        end
        else if (frame_reg == FRAME_HOME)
        begin
            frame_value = CMD_HOME;
        end
        else
        begin
            frame_value = job_value_reg;
        end
        case (byte_reg)
            BYTE_START: out_serial.serial_byte = START_BYTE | (frame_is_char ? RS_BIT : 8'h00);
            BYTE_LO:    out_serial.serial_byte = {rev_nibble(frame_value[3:0]), 4'b0000};
            default:    out_serial.serial_byte = {rev_nibble(frame_value[7:4]), 4'b0000};
        endcase
    end

    assign out_serial.valid     = job_valid_reg;
    assign out_serial.frame_end = (byte_reg == BYTE_HI);
    assign out_serial.run_end   = last_byte;

    // A start-of-text transfer always opens with a command telegram
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_text.first_of_text |=>
            out_serial.valid && (out_serial.serial_byte == START_BYTE))
        else $error("start of text did not begin with a command telegram");

    // A lone 0xC3 lead byte is held as the pending lead
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !in_text.first_of_text && (pend_reg == PEND_NONE) &&
        (in_text.text_byte == LEAD_C3) |=> (pend_reg == PEND_C3))
        else $error("lead byte 0xC3 not held");

    // The last byte of a run always closes a telegram
    assert property (@(posedge clk) disable iff (!rst_n)
        out_serial.valid && out_serial.run_end |-> out_serial.frame_end)
        else $error("run ended inside a telegram");

    // The held lead code never takes the unused value
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == PEND_NONE) || (pend_reg == PEND_C3) || (pend_reg == PEND_C2))
        else $error("invalid held lead code");

endmodule

### bench/lcd_text_to_serial_frames_tb.sv
`timescale 1ns / 1ps
// Self-checking bench: UTF-8 text bytes in, predicted LCD serial telegrams checked out.
module lcd_text_to_serial_frames_tb;
    import lcdtx_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 4;

    localparam byte_t UMLAUT_SRC [7] = '{8'hA4, 8'hB6, 8'hBC, 8'h84, 8'h96, 8'h9C, 8'h9F};
    localparam byte_t UMLAUT_DST [7] = '{8'hE4, 8'hF6, 8'hFC, 8'hC4, 8'hD6, 8'hDC, 8'hDF};

    typedef struct packed {
        byte_t text_byte;
        logic  first_of_text;
    } text_item_t;

    typedef struct packed {
        byte_t serial_byte;
        logic  frame_end;
        logic  run_end;
    } tel_byte_t;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_mode_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_wr_en;
    byte_t cfg_wr_data;

    lcdtx_text_if   txt();
    lcdtx_serial_if ser();

    lcd_text_to_serial_frames DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_text     (txt),
        .out_serial  (ser)
    );

    text_item_t pending_text [$];
    tel_byte_t  telegram_bytes_due [$];

    lead_t      held_lead;
    byte_t      subst_shadow;
    idle_mode_t idle_mode;

    logic       text_taken;
    logic       serial_taken;
    int         send_wait;
    int         stall_left;
    int         idle_cycles;
    int         errors;
    int         items_taken;
    int         bytes_checked;
    int         config_writes;
    text_item_t next_text;
    text_item_t got_text;
    tel_byte_t  head_tel;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_wait();
        int w;
        case (idle_mode)
            IDLE_NONE:  w = 0;
            IDLE_LIGHT: w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            default:    w = $urandom_range(0, 19);
        endcase
        return w;
    endfunction

    // Value bit b lands on wire bit 7-b; the low nibble of the byte stays zero.
    function automatic byte_t nibble_to_wire(input logic [3:0] nib);
        byte_t w;
        int    b;
        w = '0;
        for (b = 0; b < 4; b++)
            w[7 - b] = nib[b];
        return w;
    endfunction

    task automatic push_telegram(input logic is_char, input byte_t value, input logic last);
        tel_byte_t t;
        t.serial_byte = START_BYTE | (is_char ? RS_BIT : 8'h00);
        t.frame_end   = 1'b0;
        t.run_end     = 1'b0;
        telegram_bytes_due.push_back(t);
        t.serial_byte = nibble_to_wire(value[3:0]);
        telegram_bytes_due.push_back(t);
        t.serial_byte = nibble_to_wire(value[7:4]);
        t.frame_end   = 1'b1;
        t.run_end     = last;
        telegram_bytes_due.push_back(t);
    endtask

    task automatic predict_telegrams(input text_item_t it);
        lead_t prior;
        logic  has_char;
        byte_t ch;
        int    i;
        if (it.first_of_text)
            held_lead = PEND_NONE;
        prior     = held_lead;
        held_lead = PEND_NONE;
        has_char  = 1'b1;
        ch        = it.text_byte;
        if (prior == PEND_C3)
        begin
            ch = subst_shadow;
            for (i = 0; i < 7; i++)
                if (UMLAUT_SRC[i] == it.text_byte)
                    ch = UMLAUT_DST[i];
        end
        else if (prior == PEND_C2)
            ch = subst_shadow;
        else if (it.text_byte == LEAD_C3)
        begin
            held_lead = PEND_C3;
            has_char  = 1'b0;
        end
        else if (it.text_byte == LEAD_C2)
        begin
            held_lead = PEND_C2;
            has_char  = 1'b0;
        end
        if (it.first_of_text)
        begin
            push_telegram(1'b0, CMD_CLEAR, 1'b0);
            push_telegram(1'b0, CMD_HOME, !has_char);
        end
        if (has_char)
            push_telegram(1'b1, ch, 1'b1);
    endtask

    task automatic queue_text(input byte_t b, input logic first);
        text_item_t it;
        it.text_byte     = b;
        it.first_of_text = first;
        pending_text.push_back(it);
    endtask

    // Mostly well-formed text: printable ASCII, umlaut pairs, broken pairs, new texts; some noise.
    task automatic queue_random_text(input int count);
        int kind;
        int n;
        n = 0;
        while (n < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                queue_text(byte_t'($urandom_range(8'h20, 8'h7E)), $urandom_range(0, 19) == 0);
                n += 1;
            end
            else if (kind < 55)
            begin
                queue_text(LEAD_C3, $urandom_range(0, 15) == 0);
                queue_text(UMLAUT_SRC[$urandom_range(0, 6)], 1'b0);
                n += 2;
            end
            else if (kind < 65)
            begin
                queue_text(LEAD_C3, 1'b0);
                queue_text(byte_t'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                n += 2;
            end
            else if (kind < 75)
            begin
                queue_text(LEAD_C2, $urandom_range(0, 15) == 0);
                queue_text(byte_t'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                n += 2;
            end
            else if (kind < 82)
            begin
                queue_text(byte_t'($urandom_range(0, 255)), 1'b1);
                n += 1;
            end
            else
            begin
                queue_text(byte_t'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                n += 1;
            end
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_text.size() != 0 || txt.valid || telegram_bytes_due.size() != 0)
            @(posedge clk);
        // wait out SETTLE_CYCLES quiet cycles before the next phase
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_subst(input byte_t v);
        @(negedge clk);
        cfg_wr_en    = 1'b1;
        cfg_wr_data  = v;
        subst_shadow = v;
        @(negedge clk);
        cfg_wr_en    = 1'b0;
        config_writes += 1;
    endtask

    // Text side: hold until transfer, then wait the drawn gap before the next byte.
    always @(negedge clk)
    begin
        if (rst_n && (!txt.valid || text_taken))
        begin
            if (send_wait != 0)
            begin
                txt.valid <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (pending_text.size() != 0)
            begin
                next_text          = pending_text.pop_front();
                txt.valid         <= 1'b1;
                txt.text_byte     <= next_text.text_byte;
                txt.first_of_text <= next_text.first_of_text;
                send_wait         <= draw_wait();
            end
            else
                txt.valid <= 1'b0;
        end
    end

    // Serial side: stall a drawn number of cycles after each transfer.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (serial_taken)
                stall_left = draw_wait();
            if (stall_left != 0)
            begin
                ser.ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
                ser.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        text_taken   <= rst_n && txt.valid && txt.ready;
        serial_taken <= rst_n && ser.valid && ser.ready;
        if (rst_n)
        begin
            // check the output before predicting: a byte leaving now belongs to an older text byte
            if (ser.valid && ser.ready)
            begin
                if (telegram_bytes_due.size() == 0)
                begin
                    $error("unexpected serial byte %h", ser.serial_byte);
                    errors += 1;
                end
                else
                begin
                    head_tel = telegram_bytes_due.pop_front();
                    bytes_checked += 1;
                    if (ser.serial_byte !== head_tel.serial_byte)
                    begin
                        $error("serial_byte expected %h got %h", head_tel.serial_byte,
                               ser.serial_byte);
                        errors += 1;
                    end
                    if (ser.frame_end !== head_tel.frame_end)
                    begin
                        $error("frame_end expected %b got %b", head_tel.frame_end, ser.frame_end);
                        errors += 1;
                    end
                    if (ser.run_end !== head_tel.run_end)
                    begin
                        $error("run_end expected %b got %b", head_tel.run_end, ser.run_end);
                        errors += 1;
                    end
                end
            end
            if (txt.valid && txt.ready)
            begin
                got_text.text_byte     = txt.text_byte;
                got_text.first_of_text = txt.first_of_text;
                predict_telegrams(got_text);
                items_taken += 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(txt.valid && txt.ready) && !(ser.valid && ser.ready))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[lcd_text_to_serial_frames] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        txt.valid         = 1'b0;
        txt.text_byte     = '0;
        txt.first_of_text = 1'b0;
        ser.ready         = 1'b0;
        held_lead         = PEND_NONE;
        subst_shadow      = SUBST_RESET;
        idle_mode         = IDLE_LIGHT;
        send_wait         = 0;
        stall_left        = 0;
        idle_cycles       = 0;
        errors            = 0;
        items_taken       = 0;
        bytes_checked     = 0;
        config_writes     = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, umlaut pairs, broken pairs, new text dropping a held lead
        queue_text(8'h41, 1'b1);
        queue_text(8'h00, 1'b0);
        queue_text(8'hFF, 1'b0);
        queue_text(LEAD_C3, 1'b0);
        queue_text(8'hA4, 1'b0);
        queue_text(LEAD_C3, 1'b0);
        queue_text(8'h9F, 1'b0);
        queue_text(LEAD_C3, 1'b0);
        queue_text(8'h41, 1'b0);
        queue_text(LEAD_C3, 1'b0);
        queue_text(LEAD_C3, 1'b0);
        queue_text(LEAD_C2, 1'b0);
        queue_text(LEAD_C3, 1'b0);
        queue_text(LEAD_C2, 1'b0);
        queue_text(8'h00, 1'b0);
        queue_text(LEAD_C3, 1'b0);
        queue_text(8'h42, 1'b1);
        queue_text(LEAD_C3, 1'b1);
        queue_text(8'hBC, 1'b0);
        queue_text(LEAD_C2, 1'b0);
        queue_text(LEAD_C3, 1'b1);
        queue_text(8'h84, 1'b0);
        queue_text(8'h7F, 1'b0);
        wait_drained();

        write_subst(8'h00);
        idle_mode = IDLE_FULL;
        queue_random_text(100);
        wait_drained();

        write_subst(8'hFF);
        queue_random_text(50);
        // sender holds off here until every telegram byte has drained
        wait_drained();
        idle_mode = IDLE_NONE;
        queue_random_text(50);
        wait_drained();

        write_subst(byte_t'($urandom_range(0, 255)));
        idle_mode = IDLE_LIGHT;
        queue_random_text(100);
        wait_drained();

        write_subst(SUBST_RESET);
        idle_mode = IDLE_FULL;
        queue_random_text(100);
        wait_drained();

        $display("Covered %0d text bytes: umlaut pairs, broken and dropped leads, new texts",
                 items_taken);
        $display("Checked %0d telegram bytes across %0d substitute settings incl. 0x00 and 0xFF",
                 bytes_checked, config_writes + 1);
        if (errors == 0)
            $display("[lcd_text_to_serial_frames] OK");
        else
            $display("[lcd_text_to_serial_frames] ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/lcdtx_pkg.sv
hw/rtl/lcdtx_if.sv
hw/rtl/lcd_text_to_serial_frames.sv
bench/lcd_text_to_serial_frames_tb.sv
